@@ rtl/core/bfpg_pkg.sv @@
// Package for the Barnsley fern point generator.
// Holds the sequencer states, map codes, command struct and fixed constants.
// No dependencies.
`default_nettype none

package bfpg_pkg;

   // Sequencer states of the controller.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_ACCUM,
      ST_SCALE,
      ST_EMIT
   } state_type;

   // The four affine maps of the fern.
   typedef enum logic [1:0] {
      MAP_STEM,
      MAP_LEAF,
      MAP_LEFT,
      MAP_RIGHT
   } map_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_item;
      logic mult;
      logic accum;
      logic scale;
      logic load_out;
   } cmd_type;

   // Map selection thresholds on the random word (fractions 0.01, 0.86, 0.93).
   localparam logic [15:0] SEL_STEM = 16'd656;
   localparam logic [15:0] SEL_LEAF = 16'd56361;
   localparam logic [15:0] SEL_LEFT = 16'd60949;

   // Configuration register indexes and widths; unused indexes are ignored.
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 8;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PIXEL_SCALE = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_X_OFFSET    = 2'd1;

   localparam int SCALE_BITS  = 8;
   localparam int OFFSET_BITS = 4;
   localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = 8'd50;
   localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 4'd5;

   localparam int WORD_BITS  = 16;
   localparam int COLOR_BITS = 8;

   // Color base values.
   localparam logic [COLOR_BITS-1:0] RED_BASE   = 8'd250;
   localparam logic [COLOR_BITS-1:0] GREEN_BASE = 8'd50;
   localparam logic [COLOR_BITS-1:0] BLUE_BASE  = 8'd50;

endpackage

`default_nettype wire

@@ rtl/core/bfpg_ctrl.sv @@
// Controller of the fern point generator: sequences one point update per item
// and owns the result valid flag. Depends on bfpg_pkg.
`default_nettype none

module bfpg_ctrl
   import bfpg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   // The output register can take a new beat when empty or being drained.
   assign out_free = !out_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_MULT;
         ST_MULT:  state_in = ST_ACCUM;
         ST_ACCUM: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_EMIT;
         ST_EMIT:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs decoded from the state.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.take_item = req_tvalid;
         end
         ST_MULT:  cmd.mult  = 1'b1;
         ST_ACCUM: cmd.accum = 1'b1;
         ST_SCALE: cmd.scale = 1'b1;
         ST_EMIT:  cmd.load_out = out_free;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/bfpg_datapath.sv @@
// Datapath of the fern point generator: map selection, affine products,
// point registers, pixel scaling, colors and the result register.
// Depends on bfpg_pkg; driven by commands from bfpg_ctrl.
`default_nettype none

module bfpg_datapath
   import bfpg_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int COORD_BITS = 10
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   input  wire logic [WORD_BITS-1:0]     random_word,
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   output logic [COORD_BITS-1:0]         pixel_x,
   output logic [COORD_BITS-1:0]         pixel_y,
   output logic [COLOR_BITS-1:0]         red,
   output logic [COLOR_BITS-1:0]         green,
   output logic [COLOR_BITS-1:0]         blue
);

   localparam int PW     = FRAC_BITS + 8;
   localparam int COEF_W = FRAC_BITS + 2;
   localparam int PROD_W = COEF_W + PW;
   localparam int SUM_W  = PROD_W + 2;
   localparam int QW     = SUM_W - FRAC_BITS;
   localparam int SC_W   = PW + 10;

   // Coefficients: hundredths rounded to FRAC_BITS fraction bits.
   localparam logic signed [COEF_W-1:0] Q4   =
      COEF_W'(((64'd4   << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [COEF_W-1:0] Q15  =
      COEF_W'(((64'd15  << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [COEF_W-1:0] Q16  =
      COEF_W'(((64'd16  << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [COEF_W-1:0] Q20  =
      COEF_W'(((64'd20  << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [COEF_W-1:0] Q22  =
      COEF_W'(((64'd22  << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [COEF_W-1:0] Q23  =
      COEF_W'(((64'd23  << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [COEF_W-1:0] Q24  =
      COEF_W'(((64'd24  << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [COEF_W-1:0] Q26  =
      COEF_W'(((64'd26  << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [COEF_W-1:0] Q28  =
      COEF_W'(((64'd28  << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [COEF_W-1:0] Q44  =
      COEF_W'(((64'd44  << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [COEF_W-1:0] Q85  =
      COEF_W'(((64'd85  << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [COEF_W-1:0] Q160 =
      COEF_W'(((64'd160 << FRAC_BITS) + 64'd50) / 64'd100);

   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [PW-1:0]    POINT_MAX  = {1'b0, {(PW-1){1'b1}}};
   localparam logic signed [PW-1:0]    POINT_MIN  = {1'b1, {(PW-1){1'b0}}};

   // Saturate a rounded sum to the signed point range.
   function automatic logic signed [PW-1:0] sat_point(input logic signed [QW-1:0] v);
      logic all_ones;
      logic all_zeros;
      all_ones  = &v[QW-1:PW-1];
      all_zeros = ~|v[QW-1:PW-1];
      if (all_ones || all_zeros) begin
         return v[PW-1:0];
      end else if (v[QW-1]) begin
         return POINT_MIN;
      end
      return POINT_MAX;
   endfunction

   // Truncate a scaled value to a pixel, clamping below zero and at the top.
   function automatic logic [COORD_BITS-1:0] to_pixel(input logic signed [SC_W-1:0] v);
      if (v[SC_W-1]) begin
         return '0;
      end else if (|v[SC_W-2:FRAC_BITS+COORD_BITS]) begin
         return '1;
      end
      return v[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
   endfunction

   logic [SCALE_BITS-1:0]      scale_ff;
   logic [OFFSET_BITS-1:0]     offset_ff;
   map_type                    map_ff, map_in;
   logic signed [PW-1:0]       point_x_ff, point_y_ff;
   logic signed [PROD_W-1:0]   prod_ax_ff, prod_by_ff, prod_cx_ff, prod_dy_ff;
   logic signed [SC_W-1:0]     scaled_x_ff, scaled_y_ff;
   logic [COORD_BITS-1:0]      px_ff, py_ff;
   logic [COLOR_BITS-1:0]      red_ff, green_ff, blue_ff;

   logic signed [COEF_W-1:0]   coef_a, coef_b, coef_c, coef_d, const_y;
   logic signed [SUM_W-1:0]    sum_x, sum_y;
   logic signed [PW:0]         off_term, x_shifted;
   logic signed [SC_W-1:0]     scale_term;
   logic [COORD_BITS-1:0]      px_in, py_in;
   logic [COORD_BITS-1:0]      py_sh2, py_sh3, py_sh4;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RESET;
         offset_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_PIXEL_SCALE: scale_ff  <= csr_wdata[SCALE_BITS-1:0];
            CSR_X_OFFSET:    offset_ff <= csr_wdata[OFFSET_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Map selection from the random word.
   always_comb begin
      if (random_word < SEL_STEM) begin
         map_in = MAP_STEM;
      end else if (random_word < SEL_LEAF) begin
         map_in = MAP_LEAF;
      end else if (random_word < SEL_LEFT) begin
         map_in = MAP_LEFT;
      end else begin
         map_in = MAP_RIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         map_ff <= map_in;
      end
   end

   // Coefficients of the selected map.
   always_comb begin
      case (map_ff)
         MAP_STEM: begin
            coef_a = '0;   coef_b = '0;   coef_c = '0;   coef_d = Q16; const_y = '0;
         end
         MAP_LEAF: begin
            coef_a = Q85;  coef_b = Q4;   coef_c = -Q4;  coef_d = Q85; const_y = Q160;
         end
         MAP_LEFT: begin
            coef_a = Q20;  coef_b = -Q26; coef_c = Q23;  coef_d = Q22; const_y = Q160;
         end
         default: begin
            coef_a = -Q15; coef_b = Q28;  coef_c = Q26;  coef_d = Q24; const_y = Q44;
         end
      endcase
   end

   // Four products of the affine map.
   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         prod_ax_ff <= PROD_W'(coef_a) * PROD_W'(point_x_ff);
         prod_by_ff <= PROD_W'(coef_b) * PROD_W'(point_y_ff);
         prod_cx_ff <= PROD_W'(coef_c) * PROD_W'(point_x_ff);
         prod_dy_ff <= PROD_W'(coef_d) * PROD_W'(point_y_ff);
      end
   end

   // Sums with the additive constant and the half-unit rounding term.
   assign sum_x = SUM_W'(prod_ax_ff) + SUM_W'(prod_by_ff) + ROUND_HALF;
   assign sum_y = SUM_W'(prod_cx_ff) + SUM_W'(prod_dy_ff)
                + (SUM_W'(const_y) <<< FRAC_BITS) + ROUND_HALF;

   // Point registers: the new point is the rounded, saturated sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         point_x_ff <= '0;
         point_y_ff <= '0;
      end else if (cmd.accum) begin
         point_x_ff <= sat_point($signed(sum_x[SUM_W-1:FRAC_BITS]));
         point_y_ff <= sat_point($signed(sum_y[SUM_W-1:FRAC_BITS]));
      end
   end

   // Offset x by whole units, then scale both coordinates.
   assign off_term   = $signed({{(PW-3-FRAC_BITS){1'b0}}, offset_ff, {FRAC_BITS{1'b0}}});
   assign x_shifted  = $signed({point_x_ff[PW-1], point_x_ff}) + off_term;
   assign scale_term = $signed(SC_W'({1'b0, scale_ff}));

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         scaled_x_ff <= SC_W'(x_shifted) * scale_term;
         scaled_y_ff <= SC_W'(point_y_ff) * scale_term;
      end
   end

   // Pixel conversion and colors.
   assign px_in  = to_pixel(scaled_x_ff);
   assign py_in  = to_pixel(scaled_y_ff);
   assign py_sh2 = py_in >> 2;
   assign py_sh3 = py_in >> 3;
   assign py_sh4 = py_in >> 4;

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         red_ff   <= RED_BASE   - py_sh3[COLOR_BITS-1:0];
         green_ff <= GREEN_BASE + py_sh2[COLOR_BITS-1:0];
         blue_ff  <= BLUE_BASE  - py_sh4[COLOR_BITS-1:0];
      end
   end

   assign pixel_x = px_ff;
   assign pixel_y = py_ff;
   assign red     = red_ff;
   assign green   = green_ff;
   assign blue    = blue_ff;

endmodule

`default_nettype wire

@@ rtl/core/barnsley_fern_point_generator.sv @@
// Barnsley fern point generator, top level.
// A result beat is valid once its item has passed the multiply, accumulate, scale and emit states;
// emit waits while the output register holds an undrained beat. The controller takes no new item
// until it is back in idle, so items do not overlap around the point feedback register.
// Reset is synchronous, active high: point to the origin, scale 50, offset 5, no beat pending.
// Depends on bfpg_pkg, bfpg_ctrl and bfpg_datapath.
`default_nettype none

module barnsley_fern_point_generator
   import bfpg_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int COORD_BITS = 10,
   localparam int RSP_BITS  = ((2 * COORD_BITS + 3 * COLOR_BITS + 7) / 8) * 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Item beats.
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [WORD_BITS-1:0]     req_tdata,   // random_word
   // Result beats.
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_BITS-1:0]           rsp_tdata,   // pixel_x, pixel_y, red, green, blue
   // Configuration writes.
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cmd_type                 cmd;
   logic [COORD_BITS-1:0]   pixel_x, pixel_y;
   logic [COLOR_BITS-1:0]   red, green, blue;

   // Sequencer.
   bfpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Arithmetic and storage.
   bfpg_datapath #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .random_word (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .red         (red),
      .green       (green),
      .blue        (blue)
   );

   // Pack the result beat, first field lowest, zero padded to whole bytes.
   assign rsp_tdata = RSP_BITS'({blue, green, red, pixel_y, pixel_x});

endmodule

`default_nettype wire

@@ rtl/core/bfpg_checker.sv @@
// Port-level checks for the Barnsley fern point generator, bound to the top level.
// Depends on bfpg_pkg and barnsley_fern_point_generator.
`default_nettype none

module bfpg_checker
   import bfpg_pkg::*;
#(
   parameter int COORD_BITS = 10,
   localparam int RSP_BITS  = ((2 * COORD_BITS + 3 * COLOR_BITS + 7) / 8) * 8
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_BITS-1:0]      rsp_tdata    // pixel_x, pixel_y, red, green, blue
);

   logic [COORD_BITS-1:0] chk_py;
   logic [COORD_BITS-1:0] chk_py_sh3;
   logic [COLOR_BITS-1:0] chk_red;

   assign chk_py     = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
   assign chk_py_sh3 = chk_py >> 3;
   assign chk_red    = rsp_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS];

   // No result beat is pending right after reset.
   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // The block is busy, not ready, in the cycle after it takes an item.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item taken while previous item in work");

   // A stalled result beat stays valid and holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result beat changed");

   // Red always follows from the pixel row.
   a_red_matches_y: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (chk_red == RED_BASE - chk_py_sh3[COLOR_BITS-1:0]))
      else $error("red does not match pixel_y");

endmodule

bind barnsley_fern_point_generator bfpg_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);

`default_nettype wire

@@ tb/sv/fern_pixel_checker.sv @@
// Checker for the Barnsley fern point generator: watches the item, result and CSR buses,
// predicts every pixel beat from its own copy of the fern point and registers, and compares.
// Depends on bfpg_pkg for map codes, thresholds, register indexes and reset values.
`timescale 1ns / 1ps

module fern_pixel_checker
   import bfpg_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_tready,
   input  wire logic [WORD_BITS-1:0]     req_tdata,   // random_word
   input  wire logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic [47:0]              rsp_tdata,   // pixel_x, pixel_y, red, green, blue
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                            mismatch_count,
   output int                            pending
);

   localparam int     FRAC       = 16;
   localparam int     POINT_BITS = FRAC + 8;
   localparam longint ONE        = longint'(1) << FRAC;
   localparam longint POINT_MAX  = (longint'(1) << (POINT_BITS - 1)) - 1;
   localparam longint POINT_MIN  = -(longint'(1) << (POINT_BITS - 1));
   localparam longint PIXEL_MAX  = 1023;

   // One result beat, laid out as on rsp_tdata (last member in the lowest bits).
   typedef struct packed {
      logic [3:0] pad;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [9:0] pixel_y;
      logic [9:0] pixel_x;
   } fern_pixel_t;

   longint            fern_x;
   longint            fern_y;
   logic [7:0]        scale_reg;
   logic [3:0]        offset_reg;
   fern_pixel_t       expected_pixels[$];
   int                fails = 0;

   assign mismatch_count = fails;

   // Signed hundredths to fixed point; the magnitude is rounded, the sign applied after.
   function automatic longint hundredths(int h);
      longint mag;
      mag = h < 0 ? -h : h;
      mag = ((mag << FRAC) + 50) / 100;
      return h < 0 ? -mag : mag;
   endfunction

   // One row of an affine map on the current point, rounded half up and saturated.
   function automatic longint fern_row(int a, int b, int k);
      longint acc;
      acc = hundredths(a) * fern_x + hundredths(b) * fern_y + hundredths(k) * ONE;
      acc = (acc + ONE / 2) >>> FRAC;
      if (acc > POINT_MAX) acc = POINT_MAX;
      if (acc < POINT_MIN) acc = POINT_MIN;
      return acc;
   endfunction

   // Scaled fixed-point value to a pixel: negative gives zero, large values saturate.
   function automatic logic [9:0] to_pixel(longint v);
      longint p;
      if (v < 0) return '0;
      p = v >>> FRAC;
      if (p > PIXEL_MAX) p = PIXEL_MAX;
      return p[9:0];
   endfunction

   // Advances the fern point by the map that the word selects and colors the new pixel.
   function automatic fern_pixel_t step_fern(logic [WORD_BITS-1:0] word);
      map_type     map;
      longint      nx;
      longint      ny;
      fern_pixel_t pix;
      if (word < SEL_STEM)      map = MAP_STEM;
      else if (word < SEL_LEAF) map = MAP_LEAF;
      else if (word < SEL_LEFT) map = MAP_LEFT;
      else                      map = MAP_RIGHT;
      case (map)
         MAP_STEM: begin
            nx = 0;
            ny = fern_row(0, 16, 0);
         end
         MAP_LEAF: begin
            nx = fern_row(85, 4, 0);
            ny = fern_row(-4, 85, 160);
         end
         MAP_LEFT: begin
            nx = fern_row(20, -26, 0);
            ny = fern_row(23, 22, 160);
         end
         default: begin
            nx = fern_row(-15, 28, 0);
            ny = fern_row(26, 24, 44);
         end
      endcase
      fern_x = nx;
      fern_y = ny;
      pix = '0;
      pix.pixel_x = to_pixel((fern_x + longint'(offset_reg) * ONE) * longint'(scale_reg));
      pix.pixel_y = to_pixel(fern_y * longint'(scale_reg));
      pix.red     = RED_BASE - 8'(pix.pixel_y >> 3);
      pix.green   = GREEN_BASE + 8'(pix.pixel_y >> 2);
      pix.blue    = BLUE_BASE - 8'(pix.pixel_y >> 4);
      return pix;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endfunction

   // Mirror the registers, check each result beat against the oldest prediction,
   // then predict for any item beat taken at this edge.
   always @(posedge clock) begin
      fern_pixel_t got;
      fern_pixel_t want;
      if (reset) begin
         fern_x     = 0;
         fern_y     = 0;
         scale_reg  = SCALE_RESET;
         offset_reg = OFFSET_RESET;
         expected_pixels.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_PIXEL_SCALE: scale_reg  = csr_wdata[SCALE_BITS-1:0];
               CSR_X_OFFSET:    offset_reg = csr_wdata[OFFSET_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_pixels.size() == 0) begin
               $error("result beat %h arrived with no item waiting", rsp_tdata);
               fails++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_x", want.pixel_x, got.pixel_x);
               check_field("pixel_y", want.pixel_y, got.pixel_y);
               check_field("red", want.red, got.red);
               check_field("green", want.green, got.green);
               check_field("blue", want.blue, got.blue);
            end
         end
         if (req_tvalid && req_tready)
            expected_pixels.push_back(step_fern(req_tdata));
      end
      pending <= expected_pixels.size();
   end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the fern point generator testbench: clock, reset, item and CSR stimulus,
// result back-pressure and the verdict. Depends on bfpg_pkg, the RTL and fern_pixel_checker.
`timescale 1ns / 1ps

module testbench;
   import bfpg_pkg::*;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int LONG_HOLD       = 80;
   localparam int SETTLE_CYCLES   = 8;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [WORD_BITS-1:0]     req_tdata  = '0;    // random_word
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [47:0]              rsp_tdata;          // pixel_x, pixel_y, red, green, blue
   logic                     csr_wr_en  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;
   int                       mismatch_count;
   int                       pending;
   bit                       idle_on    = 1'b1;

   barnsley_fern_point_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   fern_pixel_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one word after a random gap (when gaps are on) and holds it until the beat is taken.
   task automatic send_word(logic [WORD_BITS-1:0] word);
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   // Waits until every predicted pixel has come back, then lets the pipeline settle.
   task automatic drain_pixels();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes scale and offset on consecutive edges; the offset carries junk in its upper bits.
   task automatic set_fern_config(logic [7:0] scale, logic [3:0] offset);
      csr_wr_en <= 1'b1;
      csr_addr  <= CSR_PIXEL_SCALE;
      csr_wdata <= scale;
      @(posedge clock);
      csr_addr  <= CSR_X_OFFSET;
      csr_wdata <= {4'($urandom_range(0, 15)), offset};
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly uniform words, with one in eight placed right around a map threshold.
   function automatic logic [WORD_BITS-1:0] pick_word();
      logic [WORD_BITS-1:0] edge_word;
      if ($urandom_range(0, 7) != 0) return WORD_BITS'($urandom_range(0, 65535));
      case ($urandom_range(0, 2))
         0:       edge_word = SEL_STEM;
         1:       edge_word = SEL_LEAF;
         default: edge_word = SEL_LEFT;
      endcase
      return edge_word + WORD_BITS'($urandom_range(0, 5)) - WORD_BITS'(3);
   endfunction

   // Result side: random stalls per beat, plus two long hold-offs that back the block up.
   initial begin
      int gap;
      int beats_seen;
      beats_seen = 0;
      while (reset) @(posedge clock);
      forever begin
         gap = idle_on ? $urandom_range(0, 5) : 0;
         if (beats_seen == 300 || beats_seen == 900) gap = LONG_HOLD;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         beats_seen++;
      end
   end

   // Main sequence: directed words at reset settings, then random phases over
   // several scale and offset settings.
   initial begin
      logic [WORD_BITS-1:0] directed_words[$];
      logic [7:0]           scales[PHASES];
      logic [3:0]           offsets[PHASES];
      directed_words = '{16'd0, 16'd655, 16'd656, 16'd1000, 16'd56360, 16'd56361,
                         16'd60948, 16'd60949, 16'd65535, 16'h5555, 16'hAAAA,
                         16'd30000, 16'd30000, 16'd62000, 16'd300, 16'd20000};
      // Zero scale, negative x, unit scale, saturated x and y, the defaults, then random.
      scales  = '{8'd0, 8'd255, 8'd1, 8'd255, 8'd50, 8'd0, 8'd0, 8'd0};
      offsets = '{4'd15, 4'd0, 4'd0, 4'd15, 4'd5, 4'd0, 4'd0, 4'd0};
      for (int p = 5; p < PHASES; p++) begin
         scales[p]  = 8'($urandom_range(1, 255));
         offsets[p] = 4'($urandom_range(0, 15));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_words[i]) send_word(directed_words[i]);
      req_tvalid <= 1'b0;
      drain_pixels();

      for (int p = 0; p < PHASES; p++) begin
         set_fern_config(scales[p], offsets[p]);
         idle_on = (p % 3) != 1;
         repeat (ITEMS_PER_PHASE) send_word(pick_word());
         req_tvalid <= 1'b0;
         drain_pixels();
      end

      if (mismatch_count == 0) begin
         $display("PASS barnsley_fern_point_generator");
      end else begin
         $display("FAIL barnsley_fern_point_generator");
      end
      $finish;
   end

   // Run limit, far beyond the slowest legal run.
   initial begin
      #5000000;
      $display("FAIL barnsley_fern_point_generator");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/bfpg_pkg.sv
rtl/core/bfpg_ctrl.sv
rtl/core/bfpg_datapath.sv
rtl/core/barnsley_fern_point_generator.sv
rtl/core/bfpg_checker.sv
tb/sv/fern_pixel_checker.sv
tb/sv/testbench.sv
